### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the widener checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
// Next-cycle implication, checked through reset as well
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/msw_pkg.sv
// ----------------------------------------------------------------------------
// msw_pkg
// Constants, types, microcode table and rounding/saturation helpers for the
// mid/side stereo widener.
// ----------------------------------------------------------------------------
`default_nettype none

package msw_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int DELAY_DEPTH  = 512;
    localparam int DELAY_AW     = $clog2(DELAY_DEPTH);
    localparam int DSAMP_W      = 9;
    localparam int COEF_W       = 16;
    localparam int CFG_AW       = 3;
    localparam int CFG_DW       = 16;
    // two samples, already whole bytes
    localparam int TDATA_W      = 2 * SAMPLE_WIDTH;

    // shared multiplier: signed sample-plus-one by unsigned coefficient
    localparam int MUL_A_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W  = MUL_A_W + COEF_W + 1;
    localparam int R16_W   = PROD_W + 1 - 16;
    localparam int R12_W   = PROD_W + 1 - 12;

    localparam logic signed [R12_W-1:0] SAT_HI = R12_W'((2 ** (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [R12_W-1:0] SAT_LO = ~SAT_HI;

    localparam logic [CFG_AW-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_OUTPUT_GAIN = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SIDE_GAIN   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_HP_COEF     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DELAY_EN    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_DELAY_SAMP  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_AP_EN       = 3'd6;
    localparam logic [CFG_AW-1:0] REG_AP_COEF     = 3'd7;

    localparam logic [COEF_W-1:0] GAIN_UNITY = 16'd4096;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef enum logic [3:0] {
        ST_HP_MUL,
        ST_GAIN_MUL,
        ST_GAIN_POST,
        ST_AP_MUL,
        ST_AP_POST,
        ST_LEFT_MUL,
        ST_RIGHT_MUL,
        ST_EMIT,
        ST_PASS
    } step_t;

    typedef enum logic [2:0] {A_HP, A_SIDE, A_APD, A_SUM, A_DIF} mul_a_t;
    typedef enum logic [1:0] {B_HP, B_SGAIN, B_AP, B_OGAIN} mul_b_t;
    typedef enum logic [2:0] {P_NONE, P_HP, P_GAIN, P_AP, P_LEFT, P_EMIT, P_PASS} post_t;
    typedef enum logic [1:0] {C_NONE, C_PASS, C_NO_AP} cond_t;

    typedef struct packed {
        logic   split;
        mul_a_t a_sel;
        mul_b_t b_sel;
        post_t  post;
        cond_t  cond;
        step_t  target;
    } ucode_t;

    typedef struct packed {
        logic    clip;
        sample_t val;
    } sat_t;

    // Control store: one word per step, jump taken when cond holds
    function automatic ucode_t ucode(step_t step);
        ucode_t w;
        w = '{split: 1'b0, a_sel: A_SIDE, b_sel: B_SGAIN, post: P_NONE,
              cond: C_NONE, target: ST_HP_MUL};
        case (step)
            ST_HP_MUL: begin
                w.split  = 1'b1;
                w.a_sel  = A_HP;
                w.b_sel  = B_HP;
                w.cond   = C_PASS;
                w.target = ST_PASS;
            end
            ST_GAIN_MUL: begin
                w.a_sel = A_SIDE;
                w.b_sel = B_SGAIN;
                w.post  = P_HP;
            end
            ST_GAIN_POST: begin
                w.post   = P_GAIN;
                w.cond   = C_NO_AP;
                w.target = ST_LEFT_MUL;
            end
            ST_AP_MUL: begin
                w.a_sel = A_APD;
                w.b_sel = B_AP;
            end
            ST_AP_POST: begin
                w.post = P_AP;
            end
            ST_LEFT_MUL: begin
                w.a_sel = A_SUM;
                w.b_sel = B_OGAIN;
            end
            ST_RIGHT_MUL: begin
                w.a_sel = A_DIF;
                w.b_sel = B_OGAIN;
                w.post  = P_LEFT;
            end
            ST_EMIT: begin
                w.post = P_EMIT;
            end
            ST_PASS: begin
                w.post = P_PASS;
            end
            default: begin
                w.post = P_NONE;
            end
        endcase
        return w;
    endfunction

    // round half up, drop 16 fraction bits
    function automatic logic signed [R16_W-1:0] rnd16(logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] t;
        t = {p[PROD_W-1], p} + (PROD_W + 1)'(1 << 15);
        return R16_W'(t >>> 16);
    endfunction

    // round half up, drop 12 fraction bits
    function automatic logic signed [R12_W-1:0] rnd12(logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] t;
        t = {p[PROD_W-1], p} + (PROD_W + 1)'(1 << 11);
        return R12_W'(t >>> 12);
    endfunction

    function automatic sat_t sat_s(logic signed [R12_W-1:0] x);
        sat_t r;
        if (x > SAT_HI) begin
            r.clip = 1'b1;
            r.val  = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (x < SAT_LO) begin
            r.clip = 1'b1;
            r.val  = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            r.clip = 1'b0;
            r.val  = x[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/msw_delay.sv
// ----------------------------------------------------------------------------
// msw_delay
// Circular side-signal delay line with registered read. A fill count marks
// entries written since reset; positions not yet written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module msw_delay (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [msw_pkg::DSAMP_W-1:0]  delay_samples,
    input  wire logic                         wr_en,
    input  wire msw_pkg::sample_t             wr_data,
    output msw_pkg::sample_t                  rd_data
);
    import msw_pkg::*;

    localparam int CMP_W = (DELAY_AW + 1 > DSAMP_W + 1) ? DELAY_AW + 1 : DSAMP_W + 1;

    sample_t               mem [DELAY_DEPTH];
    sample_t               rd_q_reg;
    logic                  rd_valid_reg;
    logic                  rd_valid_next;
    logic [DELAY_AW-1:0]   wp_reg;
    logic [DELAY_AW-1:0]   wp_next;
    logic [DELAY_AW:0]     fill_reg;
    logic [DELAY_AW:0]     fill_next;
    logic [CMP_W-1:0]      rd_dist;
    logic [CMP_W-1:0]      wp_ext;
    logic [CMP_W-1:0]      rd_full;
    logic [DELAY_AW-1:0]   rd_addr;

    always_comb begin
        // clamp distance to the last entry
        if (CMP_W'(delay_samples) >= CMP_W'(DELAY_DEPTH)) begin
            rd_dist = CMP_W'(DELAY_DEPTH - 1);
        end else begin
            rd_dist = CMP_W'(delay_samples);
        end
        wp_ext = CMP_W'(wp_reg);
        if (wp_ext >= rd_dist) begin
            rd_full = wp_ext - rd_dist;
        end else begin
            rd_full = wp_ext + CMP_W'(DELAY_DEPTH) - rd_dist;
        end
        rd_addr       = rd_full[DELAY_AW-1:0];
        rd_valid_next = ((DELAY_AW + 1)'(rd_addr) < fill_reg);

        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (wr_en) begin
            if (wp_reg == DELAY_AW'(DELAY_DEPTH - 1)) begin
                wp_next = '0;
            end else begin
                wp_next = wp_reg + 1'b1;
            end
            if (fill_reg < (DELAY_AW + 1)'(DELAY_DEPTH)) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // read every cycle, old data on a same-edge write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

### src/stereo_mid_side_widener.sv
// ----------------------------------------------------------------------------
// Sequencing: an item is taken only while idle; enabled, it runs the high-pass,
//   side gain, optional all-pass and left/right steps; disabled, the pass step.
// Every product goes through the one shared multiplier, one step a cycle; the
//   final step, which loads the output register, waits while that is still full.
// Reset: registers take their defaults, filter state clears, the delay line
//   reads as zero until written (fill count, no clearing pass).
// ----------------------------------------------------------------------------
// stereo_mid_side_widener
// Mid/side stereo widener run by a microcoded sequencer over a shared MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_mid_side_widener (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // left_in [23:0], right_in [47:24]
    input  wire logic [msw_pkg::TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // left_out [23:0], right_out [47:24]
    output logic [msw_pkg::TDATA_W-1:0]        m_tdata,
    // clipped [0]
    output logic                               m_tuser,
    input  wire logic                          cfg_we,
    input  wire logic [msw_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [msw_pkg::CFG_DW-1:0]    cfg_wdata
);
    import msw_pkg::*;

    // configuration
    logic                enable_reg,   enable_next;
    logic [COEF_W-1:0]   ogain_reg,    ogain_next;
    logic [COEF_W-1:0]   sgain_reg,    sgain_next;
    logic [COEF_W-1:0]   hp_coef_reg,  hp_coef_next;
    logic                dly_en_reg,   dly_en_next;
    logic [DSAMP_W-1:0]  dly_samp_reg, dly_samp_next;
    logic                ap_en_reg,    ap_en_next;
    logic [COEF_W-1:0]   ap_coef_reg,  ap_coef_next;

    // sequencer
    logic   busy_reg, busy_next;
    step_t  pc_reg,   pc_next;
    ucode_t uc;
    logic   cond_hit;
    logic   is_last;
    logic   out_free;
    logic   step_adv;
    logic   in_fire;

    // datapath
    sample_t                    l_in_reg, l_in_next;
    sample_t                    r_in_reg, r_in_next;
    sample_t                    mid_reg,  mid_next;
    logic signed [MUL_A_W-1:0]  side_reg, side_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    sample_t                    lo_reg,   lo_next;
    logic                       clip_reg, clip_next;
    sample_t                    z_reg,    z_next;
    sample_t                    ap_in_reg,  ap_in_next;
    sample_t                    ap_out_reg, ap_out_next;
    logic                       m_valid_reg, m_valid_next;
    sample_t                    m_left_reg,  m_left_next;
    sample_t                    m_right_reg, m_right_next;
    logic                       m_clip_reg,  m_clip_next;

    logic signed [MUL_A_W-1:0]  sum_in;
    logic signed [MUL_A_W-1:0]  diff_in;
    sample_t                    side_split;
    logic signed [MUL_A_W-1:0]  hp_y;
    sample_t                    side_lo;
    logic signed [MUL_A_W-1:0]  a_op;
    logic [COEF_W-1:0]          b_op;
    logic signed [R16_W-1:0]    r16;
    logic signed [R12_W-1:0]    r12;
    logic signed [R16_W:0]      z_sum;
    logic signed [R12_W-1:0]    ap_sum;
    sat_t                       sat12;
    sat_t                       ap_sat;
    logic                       dly_wr;
    sample_t                    dly_rd;

    msw_delay u_delay (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .delay_samples (dly_samp_reg),
        .wr_en         (dly_wr),
        .wr_data       (sat12.val),
        .rd_data       (dly_rd)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        uc = ucode(pc_reg);
        case (uc.cond)
            C_PASS:  cond_hit = !enable_reg;
            C_NO_AP: cond_hit = !ap_en_reg;
            default: cond_hit = 1'b0;
        endcase
        is_last  = (uc.post == P_EMIT) || (uc.post == P_PASS);
        out_free = !m_valid_reg || m_tready;
        // hold the final step while the output register is still full
        step_adv = busy_reg && (!is_last || out_free);
        in_fire  = s_tvalid && !busy_reg;

        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (in_fire) begin
            busy_next = 1'b1;
            pc_next   = ST_HP_MUL;
        end else if (step_adv) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else if (cond_hit) begin
                pc_next = uc.target;
            end else begin
                pc_next = step_t'(pc_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= ST_HP_MUL;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    // ---------------- datapath ----------------
    always_comb begin
        sum_in     = MUL_A_W'(l_in_reg) + MUL_A_W'(r_in_reg);
        diff_in    = MUL_A_W'(l_in_reg) - MUL_A_W'(r_in_reg);
        side_split = diff_in[MUL_A_W-1:1];
        hp_y       = MUL_A_W'(side_split) - MUL_A_W'(z_reg);
        side_lo    = side_reg[SAMPLE_WIDTH-1:0];

        case (uc.a_sel)
            A_HP:    a_op = hp_y;
            A_SIDE:  a_op = side_reg;
            A_APD:   a_op = MUL_A_W'(ap_out_reg) - MUL_A_W'(side_lo);
            A_SUM:   a_op = MUL_A_W'(mid_reg) + MUL_A_W'(side_lo);
            A_DIF:   a_op = MUL_A_W'(mid_reg) - MUL_A_W'(side_lo);
            default: a_op = side_reg;
        endcase
        case (uc.b_sel)
            B_HP:    b_op = hp_coef_reg;
            B_SGAIN: b_op = sgain_reg;
            B_AP:    b_op = ap_coef_reg;
            B_OGAIN: b_op = ogain_reg;
            default: b_op = ogain_reg;
        endcase

        r16    = rnd16(prod_reg);
        r12    = rnd12(prod_reg);
        sat12  = sat_s(r12);
        z_sum  = (R16_W + 1)'(z_reg) + (R16_W + 1)'(r16);
        ap_sum = R12_W'(ap_in_reg) + R12_W'(r16);
        ap_sat = sat_s(ap_sum);
        dly_wr = step_adv && (uc.post == P_GAIN) && dly_en_reg;

        l_in_next    = l_in_reg;
        r_in_next    = r_in_reg;
        mid_next     = mid_reg;
        side_next    = side_reg;
        prod_next    = prod_reg;
        lo_next      = lo_reg;
        clip_next    = clip_reg;
        z_next       = z_reg;
        ap_in_next   = ap_in_reg;
        ap_out_next  = ap_out_reg;
        m_left_next  = m_left_reg;
        m_right_next = m_right_reg;
        m_clip_next  = m_clip_reg;
        m_valid_next = m_valid_reg && !m_tready;

        if (in_fire) begin
            l_in_next = s_tdata[SAMPLE_WIDTH-1:0];
            r_in_next = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end

        if (step_adv) begin
            prod_next = PROD_W'(a_op) * PROD_W'($signed({1'b0, b_op}));
            if (uc.split) begin
                mid_next  = sum_in[MUL_A_W-1:1];
                side_next = hp_y;
                clip_next = 1'b0;
            end
            case (uc.post)
                P_HP: begin
                    z_next = z_sum[SAMPLE_WIDTH-1:0];
                end
                P_GAIN: begin
                    clip_next = clip_reg | sat12.clip;
                    // with the delay on, swap in the delayed sample; the new one goes to the line
                    side_next = dly_en_reg ? MUL_A_W'(dly_rd) : MUL_A_W'(sat12.val);
                end
                P_AP: begin
                    ap_in_next  = side_lo;
                    ap_out_next = ap_sat.val;
                    side_next   = MUL_A_W'(ap_sat.val);
                end
                P_LEFT: begin
                    lo_next   = sat12.val;
                    clip_next = clip_reg | sat12.clip;
                end
                P_EMIT: begin
                    m_left_next  = lo_reg;
                    m_right_next = sat12.val;
                    m_clip_next  = clip_reg | sat12.clip;
                    m_valid_next = 1'b1;
                end
                P_PASS: begin
                    m_left_next  = l_in_reg;
                    m_right_next = r_in_reg;
                    m_clip_next  = 1'b0;
                    m_valid_next = 1'b1;
                end
                default: begin
                    lo_next = lo_reg;
                end
            endcase
        end

        // configuration writes; clears take the filter state back to zero
        enable_next   = enable_reg;
        ogain_next    = ogain_reg;
        sgain_next    = sgain_reg;
        hp_coef_next  = hp_coef_reg;
        dly_en_next   = dly_en_reg;
        dly_samp_next = dly_samp_reg;
        ap_en_next    = ap_en_reg;
        ap_coef_next  = ap_coef_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_ENABLE:      enable_next = cfg_wdata[0];
                REG_OUTPUT_GAIN: ogain_next  = cfg_wdata;
                REG_SIDE_GAIN:   sgain_next  = cfg_wdata;
                REG_HP_COEF: begin
                    hp_coef_next = cfg_wdata;
                    if (cfg_wdata == '0) begin
                        z_next = '0;
                    end
                end
                REG_DELAY_EN:    dly_en_next   = cfg_wdata[0];
                REG_DELAY_SAMP:  dly_samp_next = cfg_wdata[DSAMP_W-1:0];
                REG_AP_EN: begin
                    ap_en_next = cfg_wdata[0];
                    if (!cfg_wdata[0]) begin
                        ap_in_next  = '0;
                        ap_out_next = '0;
                    end
                end
                REG_AP_COEF:     ap_coef_next = cfg_wdata;
                default:         ap_coef_next = ap_coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            ogain_reg    <= GAIN_UNITY;
            sgain_reg    <= GAIN_UNITY;
            hp_coef_reg  <= '0;
            dly_en_reg   <= 1'b0;
            dly_samp_reg <= '0;
            ap_en_reg    <= 1'b0;
            ap_coef_reg  <= '0;
            z_reg        <= '0;
            ap_in_reg    <= '0;
            ap_out_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            enable_reg   <= enable_next;
            ogain_reg    <= ogain_next;
            sgain_reg    <= sgain_next;
            hp_coef_reg  <= hp_coef_next;
            dly_en_reg   <= dly_en_next;
            dly_samp_reg <= dly_samp_next;
            ap_en_reg    <= ap_en_next;
            ap_coef_reg  <= ap_coef_next;
            z_reg        <= z_next;
            ap_in_reg    <= ap_in_next;
            ap_out_reg   <= ap_out_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        l_in_reg    <= l_in_next;
        r_in_reg    <= r_in_next;
        mid_reg     <= mid_next;
        side_reg    <= side_next;
        prod_reg    <= prod_next;
        lo_reg      <= lo_next;
        clip_reg    <= clip_next;
        m_left_reg  <= m_left_next;
        m_right_reg <= m_right_next;
        m_clip_reg  <= m_clip_next;
    end

    assign s_tready = !busy_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_right_reg, m_left_reg};
    assign m_tuser  = m_clip_reg;

endmodule

`default_nettype wire

### src/msw_checker.sv
// ----------------------------------------------------------------------------
// msw_checker
// Port-level checks on the widener: reset, output hold, one item in flight
// and minimum latency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msw_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [msw_pkg::TDATA_W-1:0]  m_tdata,
    input wire logic                         m_tuser
);

    `ASSERT_NEXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_tvalid, "output valid after reset")

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output item changed")

    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken while busy")

    `ASSERT_NEXT(a_min_latency, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result appeared one cycle after input")

endmodule

bind stereo_mid_side_widener msw_checker u_msw_checker (.*);

`default_nettype wire

### tb/tb_stereo_mid_side_widener.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_mid_side_widener
// Streams stereo frames through the mid/side widener under a series of
// register settings and checks every output frame against a bit-exact
// fixed-point model. The model covers the high-pass, side gain, delay line,
// all-pass and output gain stages. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_stereo_mid_side_widener;
    import msw_pkg::*;

    localparam int     HALF_PERIOD   = 10;
    localparam longint RUN_LIMIT_NS  = 5_000_000;
    localparam int     RANDOM_FRAMES = 750;
    localparam int     CALM_FRAMES   = 120;

    localparam sample_t SMP_MAX = sample_t'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam sample_t SMP_MIN = sample_t'(-(1 << (SAMPLE_WIDTH - 1)));

    typedef struct {
        sample_t left;
        sample_t right;
        logic    clip;
    } stereo_out_t;

    class widener_scoreboard;
        logic                enable;
        logic [COEF_W-1:0]   ogain;
        logic [COEF_W-1:0]   sgain;
        logic [COEF_W-1:0]   hp_coef;
        logic                dly_en;
        logic [DSAMP_W-1:0]  dly;
        logic                ap_en;
        logic [COEF_W-1:0]   ap_coef;

        logic signed [31:0]  hp_acc;
        sample_t             echo_line [DELAY_DEPTH];
        logic [DELAY_AW-1:0] echo_wr;
        sample_t             ap_x1;
        sample_t             ap_y1;

        stereo_out_t         awaited [$];
        int                  errors;
        int                  checked;
        int                  clips;

        function new();
            enable    = 1'b0;
            ogain     = GAIN_UNITY;
            sgain     = GAIN_UNITY;
            hp_coef   = '0;
            dly_en    = 1'b0;
            dly       = '0;
            ap_en     = 1'b0;
            ap_coef   = '0;
            hp_acc    = '0;
            foreach (echo_line[i]) echo_line[i] = '0;
            echo_wr   = '0;
            ap_x1     = '0;
            ap_y1     = '0;
            errors    = 0;
            checked   = 0;
            clips     = 0;
        endfunction

        // round half up, then drop n fraction bits
        function longint round_shift(longint p, int n);
            return (p + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function longint clamp(longint x, inout bit hit);
            longint hi;
            hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
            if (x > hi) begin
                hit = 1'b1;
                return hi;
            end
            if (x < -hi - 1) begin
                hit = 1'b1;
                return -hi - 1;
            end
            return x;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                REG_ENABLE:      enable = val[0];
                REG_OUTPUT_GAIN: ogain = val;
                REG_SIDE_GAIN:   sgain = val;
                REG_HP_COEF: begin
                    hp_coef = val;
                    if (val == '0) hp_acc = '0;
                end
                REG_DELAY_EN:    dly_en = val[0];
                REG_DELAY_SAMP:  dly = val[DSAMP_W-1:0];
                REG_AP_EN: begin
                    ap_en = val[0];
                    if (!val[0]) begin
                        ap_x1 = '0;
                        ap_y1 = '0;
                    end
                end
                REG_AP_COEF:     ap_coef = val;
                default: ;
            endcase
        endfunction

        function stereo_out_t widen(sample_t l, sample_t r);
            longint              mid;
            longint              side;
            longint              y;
            longint              lo;
            longint              ro;
            bit                  hit;
            bit                  ap_hit;
            logic [DELAY_AW-1:0] rd;
            stereo_out_t         res;
            hit    = 1'b0;
            ap_hit = 1'b0;
            if (!enable) begin
                res.left  = l;
                res.right = r;
                res.clip  = 1'b0;
                return res;
            end
            mid  = (longint'(l) + longint'(r)) >>> 1;
            side = (longint'(l) - longint'(r)) >>> 1;
            if (hp_coef != '0) begin
                y      = side - longint'(hp_acc);
                hp_acc = 32'(longint'(hp_acc) + round_shift(longint'(hp_coef) * y, 16));
                side   = y;
            end
            side = clamp(round_shift(side * longint'(sgain), 12), hit);
            if (dly_en) begin
                // read before write: a distance of zero returns the oldest entry
                rd                 = echo_wr - DELAY_AW'(dly);
                y                  = longint'(echo_line[rd]);
                echo_line[echo_wr] = sample_t'(side);
                echo_wr            = echo_wr + 1'b1;
                side               = y;
            end
            if (ap_en) begin
                y = longint'(ap_x1)
                  + round_shift(longint'(ap_coef) * (longint'(ap_y1) - side), 16);
                // saturation here never raises the clip flag
                y     = clamp(y, ap_hit);
                ap_x1 = sample_t'(side);
                ap_y1 = sample_t'(y);
                side  = y;
            end
            lo = clamp(round_shift((mid + side) * longint'(ogain), 12), hit);
            ro = clamp(round_shift((mid - side) * longint'(ogain), 12), hit);
            res.left  = sample_t'(lo);
            res.right = sample_t'(ro);
            res.clip  = hit;
            return res;
        endfunction

        function void take_frame(sample_t l, sample_t r);
            awaited.push_back(widen(l, r));
        endfunction

        function void check_frame(logic [TDATA_W-1:0] data, logic flag);
            stereo_out_t want;
            sample_t     got_l;
            sample_t     got_r;
            got_l = data[SAMPLE_WIDTH-1:0];
            got_r = data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
            if (awaited.size() == 0) begin
                $error("unexpected output item: left_out %0d right_out %0d", got_l, got_r);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (flag) clips++;
            if (got_l !== want.left) begin
                $error("left_out: expected %0d, actual %0d", want.left, got_l);
                errors++;
            end
            if (got_r !== want.right) begin
                $error("right_out: expected %0d, actual %0d", want.right, got_r);
                errors++;
            end
            if (flag !== want.clip) begin
                $error("clipped: expected %0b, actual %0b", want.clip, flag);
                errors++;
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                cfg_we    = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr  = '0;
    logic [CFG_DW-1:0]   cfg_wdata = '0;

    widener_scoreboard chk = new();
    bit                calm = 1'b0;
    int                stall_left = 0;
    int                sent = 0;
    int                settings = 0;

    stereo_mid_side_widener u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // output side: check accepted items, stall in random bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) chk.check_frame(m_tdata, m_tuser);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_frame(sample_t l, sample_t r);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chk.take_frame(l, r);
        sent++;
    endtask

    // hold the input side until every pending frame is out
    task automatic drain();
        if (chk.awaited.size() != 0) begin
            s_tvalid <= 1'b0;
            while (chk.awaited.size() != 0) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        chk.set_reg(idx, val);
    endtask

    task automatic write_all(bit en, logic [15:0] og, logic [15:0] sg, logic [15:0] hp,
                             bit de, logic [15:0] ds, bit ae, logic [15:0] ac);
        write_reg(REG_ENABLE, {15'($urandom), en});
        write_reg(REG_OUTPUT_GAIN, og);
        write_reg(REG_SIDE_GAIN, sg);
        write_reg(REG_HP_COEF, hp);
        write_reg(REG_DELAY_EN, {15'($urandom), de});
        write_reg(REG_DELAY_SAMP, ds);
        write_reg(REG_AP_EN, {15'($urandom), ae});
        write_reg(REG_AP_COEF, ac);
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [CFG_DW-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_UNITY;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 16383));
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_coef(logic [CFG_DW-1:0] top);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'd1;
            2:       return top;
            3:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_delay();
        logic [DSAMP_W-1:0] d;
        case ($urandom_range(0, 5))
            0:       d = '0;
            1:       d = 9'd1;
            2:       d = '1;
            3:       d = 9'($urandom_range(0, 15));
            default: d = 9'($urandom);
        endcase
        // upper bits are junk that the block must mask off
        return {7'($urandom), d};
    endfunction

    // rewrite a random subset of the registers
    task automatic random_setup();
        if ($urandom_range(0, 1)) write_reg(REG_ENABLE,
                                            {15'($urandom), 1'($urandom_range(0, 7) != 0)});
        if ($urandom_range(0, 1)) write_reg(REG_OUTPUT_GAIN, pick_gain());
        if ($urandom_range(0, 1)) write_reg(REG_SIDE_GAIN, pick_gain());
        if ($urandom_range(0, 1)) write_reg(REG_HP_COEF, pick_coef(16'd65529));
        if ($urandom_range(0, 1)) write_reg(REG_DELAY_EN, {15'($urandom), 1'($urandom)});
        if ($urandom_range(0, 1)) write_reg(REG_DELAY_SAMP, pick_delay());
        if ($urandom_range(0, 1)) write_reg(REG_AP_EN, {15'($urandom), 1'($urandom)});
        if ($urandom_range(0, 1)) write_reg(REG_AP_COEF, pick_coef(16'd64225));
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return '0;
            3:       return sample_t'(int'($urandom_range(0, 511)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        sample_t l;
        sample_t r;
        l = pick_sample();
        case ($urandom_range(0, 5))
            0:       r = l;
            1:       r = -l;
            default: r = pick_sample();
        endcase
        send_frame(l, r);
    endtask

    initial begin
        int rand_sent;
        int burst;
        rand_sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: pass-through
        send_frame(SMP_MAX, SMP_MIN);
        send_frame(SMP_MIN, SMP_MAX);
        send_frame('0, '0);
        send_frame(sample_t'(-1), sample_t'(1));
        send_frame(sample_t'(24'h555555), sample_t'(24'hAAAAAA));
        drain();

        // maximum gains: side and output saturation
        write_all(1'b1, 16'hFFFF, 16'hFFFF, '0, 1'b0, '0, 1'b0, '0);
        send_frame(SMP_MAX, SMP_MIN);
        send_frame(SMP_MIN, SMP_MAX);
        send_frame(SMP_MAX, SMP_MAX);
        send_frame('0, '0);
        drain();

        // full-scale coefficients, zero delay, all-pass driven into saturation
        write_all(1'b1, GAIN_UNITY, GAIN_UNITY, 16'hFFFF, 1'b1, 16'hFE00, 1'b1, 16'hFFFF);
        repeat (3) begin
            send_frame(SMP_MAX, SMP_MIN);
            send_frame(SMP_MIN, SMP_MAX);
        end
        drain();

        // high-pass bypass and all-pass off clear their state; delay of one
        write_all(1'b1, GAIN_UNITY, GAIN_UNITY, '0, 1'b1, 16'd1, 1'b0, 16'd64225);
        send_frame(SMP_MAX, SMP_MIN);
        send_frame('0, '0);
        send_frame(SMP_MIN, SMP_MAX);
        send_frame('0, '0);
        drain();

        // disabled with the delay on: state must stay put
        write_all(1'b0, GAIN_UNITY, GAIN_UNITY, '0, 1'b1, 16'd511, 1'b1, 16'd32768);
        send_frame(SMP_MAX, sample_t'(12345));
        send_frame(sample_t'(-7), SMP_MIN);

        while (rand_sent < RANDOM_FRAMES) begin
            drain();
            random_setup();
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                                 : $urandom_range(10, 80);
            for (int i = 0; i < burst && rand_sent < RANDOM_FRAMES; i++) begin
                calm = (rand_sent >= RANDOM_FRAMES - CALM_FRAMES);
                send_random_frame();
                rand_sent++;
                if (rand_sent == RANDOM_FRAMES / 2) drain();
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("Covered %0d frames under %0d register settings, incl. pass-through,",
                 sent, settings);
        $display("  saturation, delay wrap and filter clears; %0d checked, %0d clipped.",
                 chk.checked, chk.clips);
        if (chk.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d frames outstanding", chk.awaited.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/msw_pkg.sv
src/msw_delay.sv
src/stereo_mid_side_widener.sv
src/msw_checker.sv
tb/tb_stereo_mid_side_widener.sv
